>>> design/amfx_pkg.sv
// shared constants and types for the audio multi-effect unit
package amfx_pkg;

  localparam int HISTORY_DEPTH_DEF    = 262144;
  localparam int MAX_ECHOES_DEF       = 10;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EFFECT_MODE   = 3'd0,
    REG_ECHO_SPACING  = 3'd1,
    REG_ECHO_COUNT    = 3'd2,
    REG_LFO_STEP      = 3'd3,
    REG_SWEEP_OFFSET  = 3'd4,
    REG_SWEEP_DEPTH   = 3'd5,
    REG_DRIVE_GAIN    = 3'd6,
    REG_TREMOLO_DEPTH = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_ECHO    = 3'd0,
    MODE_FLANGER = 3'd1,
    MODE_DIST    = 3'd2,
    MODE_VIBRATO = 3'd3,
    MODE_TREMOLO = 3'd4
  } effect_mode_t;

endpackage

>>> design/amfx_mul.sv
// shared signed multiplier with registered product
module amfx_mul (
  input  logic                                 clk,
  input  logic signed [amfx_pkg::MUL_A_W-1:0]  op_a,
  input  logic signed [amfx_pkg::MUL_B_W-1:0]  op_b,
  output logic signed [amfx_pkg::MUL_P_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= amfx_pkg::MUL_P_W'(op_a) * amfx_pkg::MUL_P_W'(op_b);
  end

endmodule

>>> design/amfx_hist.sv
// sample history memory, one write and one registered read port
module amfx_hist #(
  parameter int DEPTH = amfx_pkg::HISTORY_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [15:0]   wdata,
  input  logic [AW-1:0]        raddr,
  output logic signed [15:0]   rdata_r
);

  logic signed [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> design/audio_multi_effect_unit.sv
// Audio multi-effect unit: one Q1.15 sample in, one saturated sample out per transaction.
// Modes are echo delay, flanger, distortion, vibrato and tremolo, picked by effect_mode.
// Every sample is written to a history memory and every multiplication goes through one shared
// multiplier under a sequencer, so the input is stalled while a transaction runs: after the
// accepting step comes a sine evaluation, then the steps of the mode (fewer for flanger and
// vibrato when the swept tap is absent, none for an unused mode), and in echo mode a read
// and an accumulate step per echo tap, the echo cost being set by the single history read
// port. A finished result sits in an output register, so a new sample is taken while it
// waits; a second result waits in the last step until that register frees up.
// SINE_TABLE_DEPTH must be a power of two; history entries never written may be read but
// are never used.
module audio_multi_effect_unit #(
  parameter int HISTORY_DEPTH    = amfx_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_ECHOES       = amfx_pkg::MAX_ECHOES_DEF,
  parameter int SINE_TABLE_DEPTH = amfx_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [15:0]                  out_sample,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [amfx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [amfx_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int HAW    = $clog2(HISTORY_DEPTH);
  localparam int CW     = $clog2(HISTORY_DEPTH + 1);
  localparam int IW     = $clog2(MAX_ECHOES + 2);
  localparam int DW     = 15 + IW;
  localparam int ACW    = MAX_ECHOES + 22;
  localparam int LOG_SD = $clog2(SINE_TABLE_DEPTH);
  localparam int PW     = amfx_pkg::MUL_P_W;
  localparam int AW_M   = amfx_pkg::MUL_A_W;
  localparam int BW_M   = amfx_pkg::MUL_B_W;

  typedef enum logic [21:0] {
    ST_IDLE      = 22'd1,
    ST_SIN1      = 22'd1 << 1,
    ST_SIN2      = 22'd1 << 2,
    ST_SIN3      = 22'd1 << 3,
    ST_SIN4      = 22'd1 << 4,
    ST_SIN5      = 22'd1 << 5,
    ST_ECHO_RD   = 22'd1 << 6,
    ST_ECHO_ACC  = 22'd1 << 7,
    ST_ECHO_FIN  = 22'd1 << 8,
    ST_MOD_MUL   = 22'd1 << 9,
    ST_MOD_TAU   = 22'd1 << 10,
    ST_MOD_RD0   = 22'd1 << 11,
    ST_MOD_RD1   = 22'd1 << 12,
    ST_MOD_MUL1  = 22'd1 << 13,
    ST_MOD_FIN   = 22'd1 << 14,
    ST_DIST_MUL  = 22'd1 << 15,
    ST_DIST_FIN  = 22'd1 << 16,
    ST_TREM_MUL0 = 22'd1 << 17,
    ST_TREM_MUL1 = 22'd1 << 18,
    ST_TREM_FIN  = 22'd1 << 19,
    ST_DONE      = 22'd1 << 20,
    ST_SPARE     = 22'd1 << 21
  } state_t;

  // configuration registers
  logic [2:0]  effect_mode_r;
  logic [14:0] echo_spacing_r;
  logic [3:0]  echo_count_r;
  logic [31:0] lfo_step_r;
  logic [16:0] sweep_offset_r;
  logic [16:0] sweep_depth_r;
  logic [9:0]  drive_gain_r;
  logic [14:0] tremolo_depth_r;

  state_t state_r, state_nxt;

  logic [HAW-1:0]     wp_r;
  logic [HAW-1:0]     base_r;
  logic [CW-1:0]      count_r;
  logic [31:0]        lfo_phase_r;
  logic signed [15:0] x_r;
  logic [1:0]         quarter_r;
  logic [14:0]        xq_r;
  logic [14:0]        u2_r;
  logic signed [15:0] s_r;
  logic signed [ACW-1:0] acc_r;
  logic [IW-1:0]      i_r;
  logic [IW-1:0]      n_r;
  logic [DW-1:0]      d_r;
  logic               tap_ok_r;
  logic [19:0]        far_r;
  logic [7:0]         delta_r;
  logic               absent_r;
  logic signed [25:0] w_r;
  logic signed [15:0] res_r;
  logic               res_sat_r;
  logic               out_valid_r;
  logic signed [15:0] out_sample_r;
  logic               out_sat_r;

  logic signed [AW_M-1:0] op_a;
  logic signed [BW_M-1:0] op_b;
  logic signed [PW-1:0]   prod_r;
  logic [HAW-1:0]         raddr;
  logic signed [15:0]     rdata_r;

  logic               accept;
  logic [15:0]        sin_ang;
  logic [14:0]        xq_in;
  logic [16:0]        t17;
  logic [14:0]        t_clamp;
  logic [IW-1:0]      ech_sh;
  logic signed [ACW-1:0] tap_ext;
  logic signed [ACW-1:0] tap3;
  logic signed [ACW-1:0] ech_rnd;
  logic signed [PW-1:0]  tau_tmp;
  logic signed [19:0]    tau;
  logic signed [19:0]    far;
  logic [19:0]           ntau;
  logic                  far_absent;
  logic signed [25:0]    w_sum;
  logic signed [25:0]    mod_v;
  logic signed [25:0]    mod_rnd;
  logic signed [PW-1:0]  trem_rnd;
  logic signed [PW-1:0]  dist_v;
  logic                  out_free;

  function automatic logic [16:0] sat16(input logic signed [47:0] v);
    logic [16:0] r;
    if (v > 48'sd32767) begin
      r = {1'b1, 16'h7fff};
    end else if (v < -48'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

  function automatic logic [HAW-1:0] hist_addr(input logic [HAW-1:0] base,
                                               input logic [CW-1:0] dly);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(HISTORY_DEPTH) - (CW+1)'(dly);
    if (sum >= (CW+1)'(HISTORY_DEPTH)) begin
      sum = sum - (CW+1)'(HISTORY_DEPTH);
    end
    return sum[HAW-1:0];
  endfunction

  amfx_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  amfx_hist #(.DEPTH(HISTORY_DEPTH)) u_hist (
    .clk     (clk),
    .we      (accept),
    .waddr   (wp_r),
    .wdata   (in_sample),
    .raddr   (raddr),
    .rdata_r (rdata_r)
  );

  assign accept    = (state_r == ST_IDLE) && in_valid;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_saturated = out_sat_r;
  assign out_free      = !out_valid_r || !out_stall;

  // lfo angle in 1/65536 turn, folded to a quarter wave
  assign sin_ang = {lfo_phase_r[31 -: LOG_SD], {(16-LOG_SD){1'b0}}};
  assign xq_in   = sin_ang[14] ? 15'(15'd16384 - {1'b0, sin_ang[13:0]})
                               : {1'b0, sin_ang[13:0]};
  assign t17     = prod_r[30:14];
  assign t_clamp = (t17 > 17'd32767) ? 15'h7fff : t17[14:0];

  assign ech_sh  = IW'(MAX_ECHOES) - i_r;
  assign tap_ext = ACW'(rdata_r);
  assign tap3    = (tap_ext + (tap_ext <<< 1)) <<< ech_sh;
  assign ech_rnd = (acc_r + (ACW'(1) <<< (MAX_ECHOES + 1))) >>> (MAX_ECHOES + 2);

  // modulated delay in Q.8 and its neighbour taps
  assign tau_tmp    = (prod_r + (PW'(1) <<< 14)) >>> 15;
  assign tau        = 20'(sweep_offset_r) + tau_tmp[19:0];
  assign far        = (tau + 20'sd255) >>> 8;
  assign ntau       = -tau;
  assign far_absent = (far < 20'sd1) || (32'(far) >= 32'(count_r));

  assign w_sum   = w_r + prod_r[25:0];
  assign mod_v   = ((effect_mode_r == amfx_pkg::MODE_FLANGER) ? (26'(x_r) <<< 8) : 26'sd0)
                   + w_sum;
  assign mod_rnd = (mod_v + 26'sd128) >>> 8;

  assign trem_rnd = (prod_r + (PW'(1) <<< 29)) >>> 30;

  always_comb begin
    if (prod_r > PW'(32768)) begin
      dist_v = PW'(32768);
    end else if (prod_r < -PW'(32768)) begin
      dist_v = -PW'(32768);
    end else begin
      dist_v = prod_r;
    end
  end

  // multiplier operands and read address per step
  always_comb begin
    op_a  = '0;
    op_b  = '0;
    raddr = base_r;
    case (state_r)
      ST_SIN1: begin
        op_a = AW_M'(xq_r);
        op_b = BW_M'(xq_r);
      end
      ST_SIN2: begin
        op_a = AW_M'(2451);
        op_b = BW_M'(prod_r[28:14]);
      end
      ST_SIN3: begin
        op_a = AW_M'(17'd21148 - t17);
        op_b = BW_M'(u2_r);
      end
      ST_SIN4: begin
        op_a = AW_M'(17'd51466 - t17);
        op_b = BW_M'(xq_r);
      end
      ST_ECHO_RD: raddr = hist_addr(base_r, CW'(d_r));
      ST_MOD_MUL: begin
        op_a = AW_M'(sweep_depth_r);
        op_b = BW_M'(s_r);
      end
      ST_MOD_RD0: raddr = hist_addr(base_r, CW'(far_r - 20'd1));
      ST_MOD_RD1: begin
        raddr = hist_addr(base_r, CW'(far_r));
        op_a  = AW_M'(rdata_r);
        op_b  = BW_M'(delta_r);
      end
      ST_MOD_MUL1: begin
        op_a = AW_M'(rdata_r);
        op_b = BW_M'(9'd256 - {1'b0, delta_r});
      end
      ST_DIST_MUL: begin
        op_a = AW_M'(x_r);
        op_b = BW_M'(drive_gain_r);
      end
      ST_TREM_MUL0: begin
        op_a = AW_M'(tremolo_depth_r);
        op_b = BW_M'(s_r);
      end
      ST_TREM_MUL1: begin
        op_a = (AW_M'(1) <<< 30) + prod_r[AW_M-1:0];
        op_b = BW_M'(x_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_SIN1;
      ST_SIN1:      state_nxt = ST_SIN2;
      ST_SIN2:      state_nxt = ST_SIN3;
      ST_SIN3:      state_nxt = ST_SIN4;
      ST_SIN4:      state_nxt = ST_SIN5;
      ST_SIN5: begin
        case (effect_mode_r)
          amfx_pkg::MODE_ECHO:    state_nxt = ST_ECHO_RD;
          amfx_pkg::MODE_FLANGER: state_nxt = ST_MOD_MUL;
          amfx_pkg::MODE_VIBRATO: state_nxt = ST_MOD_MUL;
          amfx_pkg::MODE_DIST:    state_nxt = ST_DIST_MUL;
          amfx_pkg::MODE_TREMOLO: state_nxt = ST_TREM_MUL0;
          default:                state_nxt = ST_DONE;
        endcase
      end
      ST_ECHO_RD:   state_nxt = (i_r > n_r) ? ST_ECHO_FIN : ST_ECHO_ACC;
      ST_ECHO_ACC:  state_nxt = ST_ECHO_RD;
      ST_ECHO_FIN:  state_nxt = ST_DONE;
      ST_MOD_MUL:   state_nxt = ST_MOD_TAU;
      ST_MOD_TAU:   state_nxt = ST_MOD_RD0;
      ST_MOD_RD0:   state_nxt = absent_r ? ST_MOD_FIN : ST_MOD_RD1;
      ST_MOD_RD1:   state_nxt = ST_MOD_MUL1;
      ST_MOD_MUL1:  state_nxt = ST_MOD_FIN;
      ST_MOD_FIN:   state_nxt = ST_DONE;
      ST_DIST_MUL:  state_nxt = ST_DIST_FIN;
      ST_DIST_FIN:  state_nxt = ST_DONE;
      ST_TREM_MUL0: state_nxt = ST_TREM_MUL1;
      ST_TREM_MUL1: state_nxt = ST_TREM_FIN;
      ST_TREM_FIN:  state_nxt = ST_DONE;
      ST_DONE:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      wp_r            <= '0;
      count_r         <= '0;
      lfo_phase_r     <= '0;
      out_valid_r     <= 1'b0;
      effect_mode_r   <= 3'd0;
      echo_spacing_r  <= 15'd18000;
      echo_count_r    <= 4'd10;
      lfo_step_r      <= 32'd44739;
      sweep_offset_r  <= 17'd49152;
      sweep_depth_r   <= 17'd49152;
      drive_gain_r    <= 10'd100;
      tremolo_depth_r <= 15'd16384;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          amfx_pkg::REG_EFFECT_MODE:   effect_mode_r   <= cfg_data[2:0];
          amfx_pkg::REG_ECHO_SPACING:  echo_spacing_r  <= cfg_data[14:0];
          amfx_pkg::REG_ECHO_COUNT:    echo_count_r    <= cfg_data[3:0];
          amfx_pkg::REG_LFO_STEP:      lfo_step_r      <= cfg_data;
          amfx_pkg::REG_SWEEP_OFFSET:  sweep_offset_r  <= cfg_data[16:0];
          amfx_pkg::REG_SWEEP_DEPTH:   sweep_depth_r   <= cfg_data[16:0];
          amfx_pkg::REG_DRIVE_GAIN:    drive_gain_r    <= cfg_data[9:0];
          amfx_pkg::REG_TREMOLO_DEPTH: tremolo_depth_r <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (accept) begin
        wp_r        <= (wp_r == HAW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + HAW'(1);
        lfo_phase_r <= lfo_phase_r + lfo_step_r;
        if (count_r < CW'(HISTORY_DEPTH)) begin
          count_r <= count_r + CW'(1);
        end
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        x_r       <= in_sample;
        base_r    <= wp_r;
        quarter_r <= sin_ang[15:14];
        xq_r      <= xq_in;
      end
      ST_SIN2: u2_r <= prod_r[28:14];
      ST_SIN5: begin
        s_r   <= quarter_r[1] ? -16'(t_clamp) : 16'(t_clamp);
        acc_r <= ACW'(x_r) <<< (MAX_ECHOES + 2);
        i_r   <= IW'(1);
        d_r   <= DW'(echo_spacing_r);
        n_r   <= (32'(echo_count_r) > MAX_ECHOES) ? IW'(MAX_ECHOES) : IW'(echo_count_r);
        res_r     <= '0;
        res_sat_r <= 1'b0;
      end
      ST_ECHO_RD: tap_ok_r <= (32'(d_r) < 32'(count_r));
      ST_ECHO_ACC: begin
        if (tap_ok_r) begin
          acc_r <= acc_r + tap3;
        end
        i_r <= i_r + IW'(1);
        d_r <= d_r + DW'(echo_spacing_r);
      end
      ST_ECHO_FIN: {res_sat_r, res_r} <= sat16(48'(ech_rnd));
      ST_MOD_TAU: begin
        far_r    <= far;
        delta_r  <= ntau[7:0];
        absent_r <= far_absent;
        w_r      <= '0;
      end
      ST_MOD_MUL1: w_r <= prod_r[25:0];
      ST_MOD_FIN: begin
        if (absent_r && effect_mode_r == amfx_pkg::MODE_VIBRATO) begin
          res_r     <= '0;
          res_sat_r <= 1'b0;
        end else begin
          {res_sat_r, res_r} <= sat16(48'(absent_r ? (26'(x_r) <<< 8) + 26'sd128 >>> 8
                                                   : mod_rnd));
        end
      end
      ST_DIST_FIN: begin
        res_r     <= 16'(dist_v >>> 1);
        res_sat_r <= 1'b0;
      end
      ST_TREM_FIN: {res_sat_r, res_r} <= sat16(48'(trem_rnd));
      ST_DONE: begin
        if (out_free) begin
          out_sample_r <= res_r;
          out_sat_r    <= res_sat_r;
        end
      end
      default: ;
    endcase
  end

endmodule
